// File: hw/rtl/spa_pkg.sv
// Shared types and constants for the sparse polynomial adder.
package spa_pkg;

    localparam int MAX_TERMS  = 32;
    localparam int COEFF_BITS = 16;
    localparam int POWER_BITS = 8;
    localparam int SUM_BITS   = COEFF_BITS + 1;
    localparam int IDX_W      = $clog2(MAX_TERMS + 1);
    localparam int ADDR_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    typedef enum logic [1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_START  = 2'd2
    } t_func;

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [COEFF_BITS-1:0] coeff_in;
        logic [POWER_BITS-1:0]        power_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] coeff_out;
        logic [POWER_BITS-1:0]      power_out;
        logic                       empty_result;
        logic                       last_term;
    } t_out_item;

    typedef struct packed {
        logic signed [COEFF_BITS-1:0] coeff;
        logic [POWER_BITS-1:0]        power;
    } t_term;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_stat;

endpackage

// File: hw/rtl/spa_ctrl.sv
// Controller: accepts load and start beats, sequences the merge.
module spa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_func,
    input  spa_pkg::t_dp_stat i_stat,
    output spa_pkg::t_ctrl_cmd o_cmd
);
    import spa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   in_fire;

    always_comb begin
        o_in_ready   = (r_state == ST_IDLE);
        in_fire      = i_in_valid && o_in_ready;
        o_cmd.load_a = in_fire && (i_func == FUNC_LOAD_A);
        o_cmd.load_b = in_fire && (i_func == FUNC_LOAD_B);
        o_cmd.step   = (r_state == ST_MERGE) && i_stat.out_free;
        n_state      = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_func == FUNC_START)) n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (o_cmd.step && i_stat.last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/spa_dp.sv
// Datapath: term stores, counts, merge pointers, adder and output register.
module spa_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spa_pkg::t_in_item   i_in_data,
    input  spa_pkg::t_ctrl_cmd  i_cmd,
    output spa_pkg::t_dp_stat   o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spa_pkg::t_out_item  o_out_data
);
    import spa_pkg::*;

    t_term mem_a [MAX_TERMS];
    t_term mem_b [MAX_TERMS];

    t_term r_rd_a, r_rd_b;
    logic [IDX_W-1:0] r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic [IDX_W-1:0] r_idx_a, r_idx_b, n_idx_a, n_idx_b;
    logic [IDX_W-1:0] adv_a, adv_b;
    logic             r_out_valid;
    t_out_item        r_out;
    t_term            wr_term;

    logic a_left, b_left, take_a, take_b, both_empty, last;
    logic signed [SUM_BITS-1:0] ext_a, ext_b;

    always_comb begin
        wr_term.coeff = i_in_data.coeff_in;
        wr_term.power = i_in_data.power_in;

        a_left     = r_idx_a < r_cnt_a;
        b_left     = r_idx_b < r_cnt_b;
        both_empty = (r_cnt_a == '0) && (r_cnt_b == '0);
        take_a     = a_left && (!b_left || (r_rd_a.power >= r_rd_b.power));
        take_b     = b_left && (!a_left || (r_rd_b.power >= r_rd_a.power));
        adv_a      = r_idx_a + IDX_W'(take_a);
        adv_b      = r_idx_b + IDX_W'(take_b);
        last       = both_empty || ((adv_a == r_cnt_a) && (adv_b == r_cnt_b));
        ext_a      = take_a ? SUM_BITS'(r_rd_a.coeff) : '0;
        ext_b      = take_b ? SUM_BITS'(r_rd_b.coeff) : '0;

        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_idx_a = r_idx_a;
        n_idx_b = r_idx_b;
        if (i_cmd.load_a && (r_cnt_a < IDX_W'(MAX_TERMS))) n_cnt_a = r_cnt_a + 1'b1;
        if (i_cmd.load_b && (r_cnt_b < IDX_W'(MAX_TERMS))) n_cnt_b = r_cnt_b + 1'b1;
        if (i_cmd.step) begin
            if (last) begin
                // merge done: clear counts and rewind pointers
                n_cnt_a = '0;
                n_cnt_b = '0;
                n_idx_a = '0;
                n_idx_b = '0;
            end else begin
                n_idx_a = adv_a;
                n_idx_b = adv_b;
            end
        end

        o_stat.out_free = !r_out_valid || i_out_ready;
        o_stat.last     = last;
    end

    // Stores: write at the fill count, read ahead at the next pointer value
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && (r_cnt_a < IDX_W'(MAX_TERMS)))
            mem_a[r_cnt_a[ADDR_W-1:0]] <= wr_term;
        if (i_cmd.load_b && (r_cnt_b < IDX_W'(MAX_TERMS)))
            mem_b[r_cnt_b[ADDR_W-1:0]] <= wr_term;
        r_rd_a <= mem_a[n_idx_a[ADDR_W-1:0]];
        r_rd_b <= mem_b[n_idx_b[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_idx_a     <= '0;
            r_idx_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_idx_a <= n_idx_a;
            r_idx_b <= n_idx_b;
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out.coeff_out    <= both_empty ? '0 : (ext_a + ext_b);
            r_out.power_out    <= (both_empty || !take_a) ?
                                  (both_empty ? '0 : r_rd_b.power) : r_rd_a.power;
            r_out.empty_result <= both_empty;
            r_out.last_term    <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hw/rtl/sparse_polynomial_add.sv
// Top level of the sparse polynomial adder.
// Load beats (func 0 into store A, func 1 into store B) append one term each; up to
// 32 terms per store are kept and further loads are dropped. A start beat (func 2)
// runs a two-pointer merge on descending power that emits one result beat per cycle
// while the output register is free, as fast as the two store read ports deliver the
// next terms; a merge of na and nb terms emits between max(na, nb) and na + nb beats,
// and an empty merge emits a single beat marked empty_result. Input is not taken during
// a merge; the output register lets loads for the next merge flow while the last result waits.
module sparse_polynomial_add (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spa_pkg::t_out_item o_out_data
);
    import spa_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    spa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_in_data.func),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: test/spa_term_checker.sv
// Channel monitor and scoreboard for the sparse polynomial adder.
module spa_term_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  spa_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  spa_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_beats
);
    import spa_pkg::*;

    t_term       store_a [MAX_TERMS];
    t_term       store_b [MAX_TERMS];
    int unsigned count_a;
    int unsigned count_b;
    t_out_item   expected_terms [$];
    t_out_item   oldest;
    t_term       loaded;

    function automatic t_out_item term_beat(logic signed [SUM_BITS-1:0] c,
                                            logic [POWER_BITS-1:0] p);
        t_out_item t;
        t              = '0;
        t.coeff_out    = c;
        t.power_out    = p;
        return t;
    endfunction

    task automatic predict_merge();
        int unsigned                ia;
        int unsigned                ib;
        logic signed [SUM_BITS-1:0] ca;
        logic signed [SUM_BITS-1:0] cb;
        t_out_item                  beat;
        ia = 0;
        ib = 0;
        ca = '0;
        cb = '0;
        if (count_a == 0 && count_b == 0) begin
            beat              = '0;
            beat.empty_result = 1'b1;
            beat.last_term    = 1'b1;
            expected_terms.push_back(beat);
            return;
        end
        while (ia < count_a || ib < count_b) begin
            if (ia < count_a) ca = $signed(store_a[ia].coeff);
            if (ib < count_b) cb = $signed(store_b[ib].coeff);
            if (ia < count_a && ib < count_b && store_a[ia].power == store_b[ib].power) begin
                beat = term_beat(ca + cb, store_a[ia].power);
                ia++;
                ib++;
            end else if (ib >= count_b ||
                         (ia < count_a && store_a[ia].power > store_b[ib].power)) begin
                beat = term_beat(ca, store_a[ia].power);
                ia++;
            end else begin
                beat = term_beat(cb, store_b[ib].power);
                ib++;
            end
            beat.last_term = (ia >= count_a && ib >= count_b);
            expected_terms.push_back(beat);
        end
        count_a = 0;
        count_b = 0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_terms.delete();
            count_a        = 0;
            count_b        = 0;
            o_fail_count   = 0;
            o_result_beats = 0;
        end else begin
            // Retire the output beat first: a result never belongs to a start taken
            // at the same edge.
            if (i_out_valid && i_out_ready) begin
                o_result_beats++;
                if (expected_terms.size() == 0) begin
                    $error("unexpected result beat: coeff_out %0d power_out %0d",
                           i_out_data.coeff_out, i_out_data.power_out);
                    o_fail_count++;
                end else begin
                    oldest = expected_terms.pop_front();
                    if (i_out_data.coeff_out !== oldest.coeff_out) begin
                        $error("coeff_out: expected %0d, got %0d",
                               oldest.coeff_out, i_out_data.coeff_out);
                        o_fail_count++;
                    end
                    if (i_out_data.power_out !== oldest.power_out) begin
                        $error("power_out: expected %0d, got %0d",
                               oldest.power_out, i_out_data.power_out);
                        o_fail_count++;
                    end
                    if (i_out_data.empty_result !== oldest.empty_result) begin
                        $error("empty_result: expected %0d, got %0d",
                               oldest.empty_result, i_out_data.empty_result);
                        o_fail_count++;
                    end
                    if (i_out_data.last_term !== oldest.last_term) begin
                        $error("last_term: expected %0d, got %0d",
                               oldest.last_term, i_out_data.last_term);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                loaded.coeff = i_in_data.coeff_in;
                loaded.power = i_in_data.power_in;
                case (i_in_data.func)
                    FUNC_LOAD_A: begin
                        if (count_a < MAX_TERMS) begin
                            store_a[count_a] = loaded;
                            count_a++;
                        end
                    end
                    FUNC_LOAD_B: begin
                        if (count_b < MAX_TERMS) begin
                            store_b[count_b] = loaded;
                            count_b++;
                        end
                    end
                    FUNC_START: predict_merge();
                    default: ;
                endcase
            end
        end
        o_pending = expected_terms.size();
    end

endmodule

// File: test/tb_sparse_polynomial_add.sv
// Stimulus and verdict for the sparse polynomial adder testbench.
module tb_sparse_polynomial_add;
    import spa_pkg::*;

    localparam int         CLK_HALF       = 6;
    localparam int         RESET_CYCLES   = 6;
    localparam int         RANDOM_ITEMS   = 200;
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         TIMEOUT_CYCLES = 1000000;
    localparam logic [1:0] FUNC_UNUSED    = 2'd3;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        result_beats;

    int        burst_left  = 0;
    bit        gapless     = 1'b0;
    int        beats_sent  = 0;
    int        merges_sent = 0;

    sparse_polynomial_add u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    spa_term_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_beats (result_beats)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: switch between randomly chosen stall patterns.
    initial begin : out_stall_pattern
        t_rx_mode mode;
        int       span;
        int       period;
        int       tick;
        forever begin
            mode   = t_rx_mode'($urandom_range(3, 0));
            span   = $urandom_range(64, 16);
            period = $urandom_range(8, 2);
            for (tick = 0; tick < span; tick++) begin
                @(posedge clk);
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_MOSTLY: out_ready <= ($urandom_range(3, 0) != 0);
                    RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
                    default:   out_ready <= (tick % period == 0);
                endcase
            end
        end
    end

    function automatic t_in_item beat_of(logic [1:0] f, logic signed [COEFF_BITS-1:0] c,
                                         logic [POWER_BITS-1:0] p);
        t_in_item b;
        b.func     = f;
        b.coeff_in = c;
        b.power_in = p;
        return b;
    endfunction

    function automatic logic signed [COEFF_BITS-1:0] pick_coeff();
        int unsigned pick;
        pick = $urandom_range(7, 0);
        if (pick == 0) return {1'b0, {(COEFF_BITS-1){1'b1}}};
        if (pick == 1) return {1'b1, {(COEFF_BITS-1){1'b0}}};
        return COEFF_BITS'($urandom());
    endfunction

    task automatic send_beat(t_in_item beat);
        int gap;
        if (burst_left == 0) begin
            gap = gapless ? 0 : $urandom_range(6, 0);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (beat.func != FUNC_UNUSED) beats_sent++;
        if (beat.func == FUNC_START) merges_sent++;
    endtask

    // Hold the sender until every predicted term has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
        burst_left = 0;
    endtask

    // Walk the powers downward and give each chosen power to A, B or both, so that
    // both stores stay sorted and share some powers; interleave the loads, then start.
    task automatic load_poly_pair(int unsigned density);
        t_in_item    terms_a [$];
        t_in_item    terms_b [$];
        int          p;
        int unsigned pick;
        for (p = 2**POWER_BITS - 1; p >= 0; p--) begin
            if ($urandom_range(255, 0) < density) begin
                pick = $urandom_range(2, 0);
                if (pick != 1 && terms_a.size() < MAX_TERMS + 2)
                    terms_a.push_back(beat_of(FUNC_LOAD_A, pick_coeff(), POWER_BITS'(p)));
                if (pick != 0 && terms_b.size() < MAX_TERMS + 2)
                    terms_b.push_back(beat_of(FUNC_LOAD_B, pick_coeff(), POWER_BITS'(p)));
            end
        end
        while (terms_a.size() != 0 || terms_b.size() != 0) begin
            if (terms_b.size() == 0 || (terms_a.size() != 0 && $urandom_range(1, 0) == 1))
                send_beat(terms_a.pop_front());
            else
                send_beat(terms_b.pop_front());
        end
        send_beat(beat_of(FUNC_START, COEFF_BITS'($urandom()), POWER_BITS'($urandom())));
    endtask

    // Noise: random codes, unordered loads, stray starts and ignored beats.
    task automatic send_noise();
        int n;
        int k;
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++)
            send_beat(beat_of(2'($urandom_range(3, 0)), COEFF_BITS'($urandom()),
                              POWER_BITS'($urandom())));
    endtask

    initial begin : stimulus
        int random_goal;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Merge with both stores empty.
        send_beat(beat_of(FUNC_START, 16'sd0, 8'd0));

        // Extremes: largest and smallest sums, a zero sum, a B-only term between.
        send_beat(beat_of(FUNC_LOAD_A, 16'sh7fff, 8'd255));
        send_beat(beat_of(FUNC_LOAD_B, 16'sh7fff, 8'd255));
        send_beat(beat_of(FUNC_LOAD_B, 16'sd7,    8'd200));
        send_beat(beat_of(FUNC_LOAD_A, 16'sd5,    8'd10));
        send_beat(beat_of(FUNC_LOAD_B, -16'sd5,   8'd10));
        send_beat(beat_of(FUNC_LOAD_A, 16'sh8000, 8'd0));
        send_beat(beat_of(FUNC_LOAD_B, 16'sh8000, 8'd0));
        send_beat(beat_of(FUNC_START,  16'sd0,    8'd0));

        // Unused code must be ignored.
        send_beat(beat_of(FUNC_UNUSED, 16'sh7fff, 8'hff));

        // Only one store holds terms.
        send_beat(beat_of(FUNC_LOAD_A, 16'sd1234, 8'd77));
        send_beat(beat_of(FUNC_START,  16'sd0,    8'd0));
        send_beat(beat_of(FUNC_LOAD_B, -16'sd99,  8'd0));
        send_beat(beat_of(FUNC_START,  16'sd0,    8'd0));

        // Unordered and repeated powers run through the merge unsorted.
        send_beat(beat_of(FUNC_LOAD_A, 16'sd1,    8'd3));
        send_beat(beat_of(FUNC_LOAD_A, 16'sd2,    8'd9));
        send_beat(beat_of(FUNC_LOAD_A, 16'sd6,    8'd9));
        send_beat(beat_of(FUNC_LOAD_B, 16'sd3,    8'd5));
        send_beat(beat_of(FUNC_LOAD_B, -16'sd4,   8'd9));
        send_beat(beat_of(FUNC_START,  16'sd0,    8'd0));
        drain_results();

        random_goal = beats_sent + RANDOM_ITEMS;
        // Overfill both stores once: loads past capacity drop, the merge is longest.
        load_poly_pair(2**POWER_BITS);
        while (beats_sent < random_goal) begin
            gapless = ($urandom_range(3, 0) == 0);
            if ($urandom_range(4, 0) == 0)
                send_noise();
            else
                load_poly_pair($urandom_range(12, 0));
            if ($urandom_range(5, 0) == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d beats with %0d merge starts; checked %0d result terms.",
                 beats_sent, merges_sent, result_beats);
        $display("Covered empty merges, zero sums, coefficient extremes, full stores, noise.");
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
